// ===== rtl/core/rcfe_pkg.sv =====
// rcfe_pkg: shared types, codes and constants of the rc serial frame encoder
// depends on nothing; imported by the controller, the datapath and the top level
package rcfe_pkg;

    localparam int CHANNEL_COUNT_DEF = 8;
    localparam int MAX_CHANNELS      = 16;

    // command codes
    localparam logic [2:0] CMD_SET      = 3'd0;
    localparam logic [2:0] CMD_COMMIT   = 3'd1;
    localparam logic [2:0] CMD_FAILSAFE = 3'd2;
    localparam logic [2:0] CMD_EMIT     = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;

    // configuration register indexes
    localparam int          CFG_INDEX_W  = 3;
    localparam int          CFG_DATA_W   = 12;
    localparam logic [2:0]  REG_PROTOCOL = 3'd0;
    localparam logic [2:0]  REG_ADDRESS  = 3'd1;
    localparam logic [2:0]  REG_MIN      = 3'd2;
    localparam logic [2:0]  REG_MAX      = 3'd3;
    localparam logic [2:0]  REG_CENTER   = 3'd4;

    // reset values of the registers
    localparam logic        RST_PROTOCOL = 1'b0;
    localparam logic [7:0]  RST_ADDRESS  = 8'd200;
    localparam logic [11:0] RST_MIN      = 12'd1000;
    localparam logic [11:0] RST_MAX      = 12'd2000;
    localparam logic [11:0] RST_CENTER   = 12'd1500;

    // result kinds
    localparam logic RESULT_FRAME = 1'b0;
    localparam logic RESULT_READ  = 1'b1;

    // frame bytes
    localparam logic [7:0] SBUS_SYNC      = 8'h0F;
    localparam logic [7:0] SBUS_FAILSAFE  = 8'h0C;
    localparam logic [7:0] CRSF_LEN       = 8'd24;
    localparam logic [7:0] CRSF_TYPE      = 8'h16;
    localparam logic [7:0] CRC_POLY       = 8'hD5;

    // byte positions inside a frame
    localparam logic [4:0] HDR_LAST_SBUS  = 5'd0;
    localparam logic [4:0] HDR_LAST_CRSF  = 5'd2;
    localparam logic [4:0] DATA_LAST_SBUS = 5'd22;
    localparam logic [4:0] DATA_LAST_CRSF = 5'd24;
    localparam logic [4:0] POS_SBUS_END   = 5'd24;

    // us to serial conversion: n = 16*us - CONV_OFFSET, value = n / 10
    localparam logic [15:0] CONV_OFFSET   = 16'd14075;
    localparam logic [15:0] CONV_LOW_T    = 16'd15795;
    localparam logic [15:0] CONV_HIGH_T   = 16'd32195;
    localparam logic [15:0] RECIP_10      = 16'hCCCD;
    localparam logic [10:0] SERIAL_CENTER = 11'd992;
    localparam logic [10:0] SERIAL_MIN    = 11'd172;
    localparam logic [10:0] SERIAL_MAX    = 11'd1811;
    localparam logic [4:0]  SERIAL_BITS   = 5'd11;
    localparam logic [4:0]  BYTE_BITS     = 5'd8;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  channel_index;
        logic [11:0] pulse_width;
        logic        failsafe_on;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  frame_byte;
        logic        last_byte;
        logic [11:0] read_pulse;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_DATA,
        ST_CONV,
        ST_LOAD,
        ST_TAIL,
        ST_READ
    } ctrl_state_t;

    typedef enum logic [3:0] {
        SRC_SYNC,
        SRC_ADDR,
        SRC_LEN,
        SRC_TYPE,
        SRC_DATA,
        SRC_FLAGS,
        SRC_ZERO,
        SRC_CRC,
        SRC_READ
    } byte_src_t;

    typedef struct packed {
        logic      take;
        logic      init;
        logic      conv;
        logic      load;
        logic      push;
        byte_src_t src;
        logic      last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic acc_ge8;
        logic crsf;
    } dp_stat_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/rc_serial_frame_encoder_core.sv =====
// rc_serial_frame_encoder_core: top level of the sbus / crsf channel frame encoder
// depends on rcfe_pkg, rcfe_ctrl and rcfe_dp
//
//   port group   direction  handshake          contents
//   in_*         in         in_valid/in_ready  command word (in_item_t)
//   out_*        out        out_valid/out_ready one frame byte or read answer (out_item_t)
//   cfg_*        in         cfg_we             register write, no read-back
//
// set, commit and set failsafe are done in the cycle they are taken; a read passes through the read state to its answer
// an emit keeps the block busy until its last byte is pushed, and longer while out_ready is low;
// besides pushing its words, it takes each of the 16 channels through a byte check,
// a multiply in the shared converter and a load into the packer
// results leave through a one-word output register, so a new word can enter in the same cycle
// the last one is taken; a stalled output holds the sequencer in place
// reset is asynchronous, active low, and sets both channel stores to 1500 us
module rc_serial_frame_encoder_core #(
    parameter int CHANNEL_COUNT = rcfe_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  rcfe_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output rcfe_pkg::out_item_t              out_data,
    input  logic                             cfg_we,
    input  logic [rcfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rcfe_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    rcfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .stat       (stat),
        .in_ready   (in_ready),
        .cmd        (cmd)
    );

    rcfe_dp #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_ready (out_ready),
        .stat      (stat),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> stat.out_free)
        else $error("word pushed into a full output register");

    a_load_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> $past(cmd.conv))
        else $error("channel load without a conversion before it");

    a_conv_needed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.conv |-> !stat.acc_ge8)
        else $error("conversion started while a full byte was pending");

    a_read_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.result_kind == RESULT_READ) |->
            (out_data.last_byte && out_data.frame_byte == 8'h00))
        else $error("read answer malformed");

endmodule

// ===== rtl/core/rcfe_ctrl.sv =====
// rcfe_ctrl: sequencer for command handling and frame byte order
// depends on rcfe_pkg; drives the datapath through ctrl_cmd_t only
module rcfe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2:0]        in_command,
    input  rcfe_pkg::dp_stat_t stat,
    output logic              in_ready,
    output rcfe_pkg::ctrl_cmd_t cmd
);
    import rcfe_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [4:0]  pos_reg, pos_next;
    logic [4:0]  hdr_last;
    logic [4:0]  data_last;

    assign hdr_last  = stat.crsf ? HDR_LAST_CRSF : HDR_LAST_SBUS;
    assign data_last = stat.crsf ? DATA_LAST_CRSF : DATA_LAST_SBUS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                pos_next = '0;
                if (in_valid)
                begin
                    priority if (in_command == CMD_EMIT)
                        state_next = ST_HEAD;
                    else if (in_command == CMD_READ)
                        state_next = ST_READ;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_HEAD:
            begin
                if (stat.out_free)
                begin
                    pos_next = pos_reg + 5'd1;
                    if (pos_reg == hdr_last)
                        state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (stat.acc_ge8)
                begin
                    if (stat.out_free)
                    begin
                        pos_next = pos_reg + 5'd1;
                        if (pos_reg == data_last)
                            state_next = ST_TAIL;
                    end
                end
                else
                    state_next = ST_CONV;
            end
            ST_CONV: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DATA;
            ST_TAIL:
            begin
                if (stat.out_free)
                begin
                    pos_next = pos_reg + 5'd1;
                    if (stat.crsf || pos_reg == POS_SBUS_END)
                        state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '{take: 1'b0, init: 1'b0, conv: 1'b0, load: 1'b0, push: 1'b0,
                     src: SRC_ZERO, last: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                cmd.init = in_valid && (in_command == CMD_EMIT);
            end
            ST_HEAD:
            begin
                cmd.push = stat.out_free;
                priority if (!stat.crsf)
                    cmd.src = SRC_SYNC;
                else if (pos_reg == 5'd0)
                    cmd.src = SRC_ADDR;
                else if (pos_reg == 5'd1)
                    cmd.src = SRC_LEN;
                else
                    cmd.src = SRC_TYPE;
            end
            ST_DATA:
            begin
                cmd.push = stat.acc_ge8 && stat.out_free;
                cmd.src  = SRC_DATA;
            end
            ST_CONV: cmd.conv = 1'b1;
            ST_LOAD: cmd.load = 1'b1;
            ST_TAIL:
            begin
                cmd.push = stat.out_free;
                priority if (stat.crsf)
                begin
                    cmd.src  = SRC_CRC;
                    cmd.last = 1'b1;
                end
                else if (pos_reg == POS_SBUS_END)
                begin
                    cmd.src  = SRC_ZERO;
                    cmd.last = 1'b1;
                end
                else
                    cmd.src = SRC_FLAGS;
            end
            ST_READ:
            begin
                cmd.push = stat.out_free;
                cmd.src  = SRC_READ;
                cmd.last = 1'b1;
            end
            default: in_ready = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/rcfe_dp.sv =====
// rcfe_dp: configuration, channel stores, converter, bit packer, crc and output word
// depends on rcfe_pkg; steered by rcfe_ctrl through ctrl_cmd_t
module rcfe_dp #(
    parameter int CHANNEL_COUNT = rcfe_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rcfe_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rcfe_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  rcfe_pkg::in_item_t                    in_data,
    input  rcfe_pkg::ctrl_cmd_t                   cmd,
    input  logic                                  out_ready,
    output rcfe_pkg::dp_stat_t                    stat,
    output logic                                  out_valid,
    output rcfe_pkg::out_item_t                   out_data
);
    import rcfe_pkg::*;

    localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // configuration
    logic        protocol_reg;
    logic [7:0]  address_reg;
    logic [11:0] min_reg;
    logic [11:0] max_reg;
    logic [11:0] center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_reg <= RST_PROTOCOL;
            address_reg  <= RST_ADDRESS;
            min_reg      <= RST_MIN;
            max_reg      <= RST_MAX;
            center_reg   <= RST_CENTER;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROTOCOL: protocol_reg <= cfg_data[0];
                REG_ADDRESS:  address_reg  <= cfg_data[7:0];
                REG_MIN:      min_reg      <= cfg_data;
                REG_MAX:      max_reg      <= cfg_data;
                REG_CENTER:   center_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // channel stores and failsafe
    logic [11:0] staging_reg [CHANNEL_COUNT];
    logic [11:0] frame_reg   [CHANNEL_COUNT];
    logic        failsafe_reg;
    logic        idx_ok;
    logic [IDX_W-1:0] idx;
    logic [11:0] pw_lo;
    logic [11:0] pw_clamped;
    logic [11:0] rd_reg, rd_next;

    assign idx_ok     = {1'b0, in_data.channel_index} < 5'(CHANNEL_COUNT);
    assign idx        = in_data.channel_index[IDX_W-1:0];
    assign pw_lo      = (in_data.pulse_width < min_reg) ? min_reg : in_data.pulse_width;
    assign pw_clamped = (pw_lo > max_reg) ? max_reg : pw_lo;
    assign rd_next    = idx_ok ? staging_reg[idx] : center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNEL_COUNT; k++)
            begin
                staging_reg[k] <= RST_CENTER;
                frame_reg[k]   <= RST_CENTER;
            end
            failsafe_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            unique case (in_data.command)
                CMD_SET:
                begin
                    if (idx_ok)
                        staging_reg[idx] <= pw_clamped;
                end
                CMD_COMMIT:
                begin
                    for (int k = 0; k < CHANNEL_COUNT; k++)
                        frame_reg[k] <= staging_reg[k];
                end
                CMD_FAILSAFE: failsafe_reg <= in_data.failsafe_on;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && in_data.command == CMD_READ)
            rd_reg <= rd_next;
    end

    // converter: one channel per conv/load pair, product registered in between
    logic [3:0]  ch_reg, ch_next;
    logic        ch_used;
    logic [11:0] conv_us;
    logic [15:0] conv_t;
    logic [14:0] conv_n;
    logic [30:0] prod_reg, prod_next;
    logic        lo_reg, hi_reg, unused_reg;
    logic [10:0] serial_val;

    assign ch_used   = {1'b0, ch_reg} < 5'(CHANNEL_COUNT);
    assign conv_us   = ch_used ? frame_reg[ch_reg[IDX_W-1:0]] : RST_CENTER;
    assign conv_t    = {conv_us, 4'b0000};
    assign conv_n    = 15'(conv_t - CONV_OFFSET);
    assign prod_next = 31'(conv_n) * 31'(RECIP_10);

    always_ff @(posedge clk)
    begin
        if (cmd.conv)
        begin
            prod_reg   <= prod_next;
            lo_reg     <= conv_t < CONV_LOW_T;
            hi_reg     <= conv_t >= CONV_HIGH_T;
            unused_reg <= !ch_used;
        end
    end

    always_comb
    begin
        priority if (unused_reg)
            serial_val = SERIAL_CENTER;
        else if (lo_reg)
            serial_val = SERIAL_MIN;
        else if (hi_reg)
            serial_val = SERIAL_MAX;
        else
            serial_val = prod_reg[29:19];
    end

    // bit packer, lsb first
    logic [17:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [7:0]  crc_reg, crc_next;
    logic        crc_take;
    logic [7:0]  byte_val;

    assign ch_next = cmd.init ? 4'd0 : (cmd.load ? ch_reg + 4'd1 : ch_reg);

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        priority if (cmd.init)
        begin
            acc_next = '0;
            cnt_next = '0;
        end
        else if (cmd.load)
        begin
            acc_next = acc_reg | (18'(serial_val) << cnt_reg);
            cnt_next = cnt_reg + SERIAL_BITS;
        end
        else if (cmd.push && cmd.src == SRC_DATA)
        begin
            acc_next = acc_reg >> 8;
            cnt_next = cnt_reg - BYTE_BITS;
        end
        else
            acc_next = acc_reg;
    end

    always_comb
    begin
        unique case (cmd.src)
            SRC_SYNC:  byte_val = SBUS_SYNC;
            SRC_ADDR:  byte_val = address_reg;
            SRC_LEN:   byte_val = CRSF_LEN;
            SRC_TYPE:  byte_val = CRSF_TYPE;
            SRC_DATA:  byte_val = acc_reg[7:0];
            SRC_FLAGS: byte_val = failsafe_reg ? SBUS_FAILSAFE : 8'h00;
            SRC_ZERO:  byte_val = 8'h00;
            SRC_CRC:   byte_val = crc_reg;
            SRC_READ:  byte_val = 8'h00;
            default:   byte_val = 8'h00;
        endcase
    end

    // crc covers the type byte and the data bytes
    assign crc_take = cmd.push && (cmd.src == SRC_TYPE || cmd.src == SRC_DATA);
    assign crc_next = cmd.init ? 8'h00 : (crc_take ? crc8_byte(crc_reg, byte_val) : crc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg  <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
            crc_reg <= '0;
        end
        else
        begin
            ch_reg  <= ch_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
        end
    end

    // output word register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    always_comb
    begin
        out_item_next.result_kind = (cmd.src == SRC_READ) ? RESULT_READ : RESULT_FRAME;
        out_item_next.frame_byte  = byte_val;
        out_item_next.last_byte   = cmd.last;
        out_item_next.read_pulse  = (cmd.src == SRC_READ) ? rd_reg : 12'd0;
        priority if (cmd.push)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            out_item_reg <= out_item_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_item_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.acc_ge8  = cnt_reg >= BYTE_BITS;
    assign stat.crsf     = protocol_reg;

endmodule
